FILE: rtl/arrc_pkg.sv
// ----------------------------------------------------------------------------
// arrc_pkg
// Shared types and constants of the audio ring refill controller.
// ----------------------------------------------------------------------------
package arrc_pkg;

  localparam int POS_BITS_DEF = 32;
  localparam int BUF_BITS_DEF = 20;

  localparam int RES_MAX   = 6;
  localparam int CNT_W     = $clog2(RES_MAX + 1);
  localparam int FREE_MIN  = 1024;
  localparam int FILL_GAP  = 256;

  localparam int BSIZE_W   = 21;
  localparam int DSIZE_W   = 31;
  localparam int CUR_W     = 20;
  localparam int OFF_W     = 20;
  localparam int LEN_W     = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [BSIZE_W-1:0] BSIZE_RST = 21'd65536;
  localparam logic [DSIZE_W-1:0] DSIZE_RST = 31'd1048576;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 2'd2;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_SILENCE = 3'd1,
    KIND_REWIND  = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_NONE    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_ONCE = 2'd1,
    MODE_LOOP = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_STOP,
    ST_START_INIT,
    ST_TICK,
    ST_TICK_WRAP,
    ST_TICK_PLAY,
    ST_TICK_CHK,
    ST_TICK_ROOM,
    ST_TICK_FILLN,
    ST_FILL_REL,
    ST_FILL_CHK,
    ST_SPAN_MOD,
    ST_SPAN_WAIT,
    ST_PIECE_MOD,
    ST_PIECE_WAIT,
    ST_PIECE,
    ST_FILL_AFTER,
    ST_END
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } out_push_t;

endpackage

FILE: rtl/arrc_mod_unit.sv
// ----------------------------------------------------------------------------
// arrc_mod_unit
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module arrc_mod_unit import arrc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int BUF_BITS = BUF_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [POS_BITS-1:0] dvd_i,
  input  logic [BUF_BITS:0]   dvs_i,
  output logic                done_o,
  output logic [BUF_BITS:0]   rem_o
);

  localparam int RB    = BUF_BITS + 1;
  localparam int ITER_W = $clog2(POS_BITS);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [POS_BITS-1:0] sh_q, sh_d;
  logic [RB-1:0]     rem_q, rem_d;
  logic [RB:0]       cat;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    cat    = {rem_q, sh_q[POS_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(POS_BITS - 1);
      sh_d   = dvd_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d = {sh_q[POS_BITS-2:0], 1'b0};
      // partial remainder stays below the divisor, so one subtract is enough
      if (cat >= {1'b0, dvs_i}) begin
        rem_d = RB'(cat - {1'b0, dvs_i});
      end else begin
        rem_d = cat[RB-1:0];
      end
      if (iter_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/arrc_seq.sv
// ----------------------------------------------------------------------------
// arrc_seq
// Sequencer and position datapath: start, tick, fill split and result queue.
// ----------------------------------------------------------------------------
module arrc_seq import arrc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int BUF_BITS = BUF_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                func_i,
  input  logic                cursor_valid_i,
  input  logic [CUR_W-1:0]    cursor_pos_i,
  input  logic [BUF_BITS:0]   ring_i,
  input  logic [DSIZE_W-1:0]  data_size_i,
  input  logic                loop_mode_i,
  input  logic                out_free_i,
  output out_push_t           push_o,
  output logic                mod_start_o,
  output logic [POS_BITS-1:0] mod_dvd_o,
  input  logic                mod_done_i,
  input  logic [BUF_BITS:0]   mod_rem_i
);

  localparam int RB  = BUF_BITS + 1;
  localparam int RMW = POS_BITS + 2;
  localparam int CW  = ((POS_BITS > DSIZE_W) ? POS_BITS : DSIZE_W) + 1;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [POS_BITS-1:0] wp_q, wp_d, sp_q, sp_d, play_q, play_d, pivot_q, pivot_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_v_q, pend_v_d;

  beat_t               pend_q, pend_d;
  logic                cvalid_q, cvalid_d;
  logic [CUR_W-1:0]    cur_q, cur_d;
  logic [POS_BITS-1:0] tmp_q, tmp_d;
  logic [RMW-1:0]      room_q, room_d;
  logic [RB-1:0]       fill_n_q, fill_n_d, first_q, first_d, span_n_q, span_n_d;
  logic [RB-1:0]       piece_n_q, piece_n_d, tail_q, tail_d, off_q, off_d;
  logic                two_q, two_d, after_q, after_d;

  logic                emit_req, emit_ok;
  kind_e               emit_kind;
  logic [RB-1:0]       emit_off, emit_len;
  logic [POS_BITS-1:0] pos_diff;
  logic [RMW-1:0]      room_n;
  logic [CW-1:0]       rel_sum, data_ext;
  logic [RB:0]         off_sum;
  logic [RB-1:0]       rest_raw, rest_m;
  logic                fill_go;

  assign data_ext   = CW'(data_size_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign mod_dvd_o  = wp_q;
  assign emit_ok    = (cnt_q == CNT_W'(RES_MAX)) || !pend_v_q || out_free_i;

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    wp_d      = wp_q;
    sp_d      = sp_q;
    play_d    = play_q;
    pivot_d   = pivot_q;
    cnt_d     = cnt_q;
    pend_v_d  = pend_v_q;
    pend_d    = pend_q;
    cvalid_d  = cvalid_q;
    cur_d     = cur_q;
    tmp_d     = tmp_q;
    room_d    = room_q;
    fill_n_d  = fill_n_q;
    first_d   = first_q;
    span_n_d  = span_n_q;
    piece_n_d = piece_n_q;
    tail_d    = tail_q;
    off_d     = off_q;
    two_d     = two_q;
    after_d   = after_q;
    emit_req  = 1'b0;
    emit_kind = KIND_DATA;
    emit_off  = '0;
    emit_len  = '0;
    push_o    = '0;
    mod_start_o = 1'b0;
    pos_diff  = wp_q - play_q;
    room_n    = room_q - RMW'(FILL_GAP);
    rel_sum   = CW'(tmp_q) + CW'(fill_n_q);
    off_sum   = (RB+1)'(mod_rem_i) + (RB+1)'(span_n_q);
    rest_raw  = fill_n_q - first_q;
    rest_m    = {rest_raw[RB-1:3], 3'b000};
    fill_go   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cvalid_d = cursor_valid_i;
          cur_d    = cursor_pos_i;
          cnt_d    = '0;
          pend_v_d = 1'b0;
          state_d  = func_i ? ST_TICK : ST_START_STOP;
        end
      end
      ST_START_STOP: begin
        if (mode_q != MODE_STOP) begin
          emit_req  = 1'b1;
          emit_kind = KIND_STOP;
          if (emit_ok) state_d = ST_START_INIT;
        end else begin
          state_d = ST_START_INIT;
        end
      end
      ST_START_INIT: begin
        emit_req  = 1'b1;
        emit_kind = KIND_REWIND;
        if (emit_ok) begin
          wp_d     = '0;
          sp_d     = '0;
          play_d   = '0;
          pivot_d  = '0;
          mode_d   = loop_mode_i ? MODE_LOOP : MODE_ONCE;
          fill_n_d = ring_i;
          state_d  = ST_FILL_REL;
        end
      end
      ST_TICK: begin
        if (mode_q == MODE_STOP) begin
          state_d = ST_END;
        end else if (!cvalid_q) begin
          // cursor read failed: playback ends without a command
          mode_d  = MODE_STOP;
          state_d = ST_END;
        end else begin
          tmp_d   = pivot_q + POS_BITS'(cur_q);
          state_d = ST_TICK_WRAP;
        end
      end
      ST_TICK_WRAP: begin
        pos_diff = tmp_q - play_q;
        if (pos_diff[POS_BITS-1]) pivot_d = pivot_q + POS_BITS'(ring_i);
        state_d = ST_TICK_PLAY;
      end
      ST_TICK_PLAY: begin
        play_d  = pivot_q + POS_BITS'(cur_q);
        state_d = ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        if (mode_q == MODE_ONCE && CW'(pivot_q) >= data_ext) begin
          emit_req  = 1'b1;
          emit_kind = KIND_STOP;
          if (emit_ok) begin
            mode_d  = MODE_STOP;
            state_d = ST_END;
          end
        end else begin
          state_d = ST_TICK_ROOM;
        end
      end
      ST_TICK_ROOM: begin
        // free room = ring size minus signed distance from cursor to writer
        room_d  = RMW'(ring_i) - {{2{pos_diff[POS_BITS-1]}}, pos_diff};
        state_d = ST_TICK_FILLN;
      end
      ST_TICK_FILLN: begin
        if ($signed(room_q) > $signed(RMW'(FREE_MIN))) begin
          if (room_n > RMW'(ring_i)) begin
            fill_n_d = ring_i;
          end else begin
            fill_n_d = room_n[RB-1:0];
          end
          state_d = ST_FILL_REL;
        end else begin
          state_d = ST_END;
        end
      end
      ST_FILL_REL: begin
        tmp_d   = wp_q - sp_q;
        state_d = ST_FILL_CHK;
      end
      ST_FILL_CHK: begin
        if (rel_sum > data_ext) begin
          // split at the data end; the head is shorter than the fill
          if (CW'(tmp_q) < data_ext) begin
            first_d  = RB'(data_ext - CW'(tmp_q));
            span_n_d = RB'(data_ext - CW'(tmp_q));
          end else begin
            first_d  = '0;
            span_n_d = '0;
          end
          after_d = 1'b1;
        end else begin
          span_n_d = fill_n_q;
          after_d  = 1'b0;
        end
        state_d = ST_SPAN_MOD;
      end
      ST_SPAN_MOD: begin
        mod_start_o = 1'b1;
        state_d     = ST_SPAN_WAIT;
      end
      ST_SPAN_WAIT: begin
        if (mod_done_i) begin
          off_d = mod_rem_i;
          if (off_sum > (RB+1)'(ring_i)) begin
            // span crosses the buffer wrap
            piece_n_d = ring_i - mod_rem_i;
            tail_d    = RB'(off_sum - (RB+1)'(ring_i));
            two_d     = 1'b1;
          end else begin
            piece_n_d = span_n_q;
            two_d     = 1'b0;
          end
          state_d = ST_PIECE;
        end
      end
      ST_PIECE_MOD: begin
        mod_start_o = 1'b1;
        state_d     = ST_PIECE_WAIT;
      end
      ST_PIECE_WAIT: begin
        if (mod_done_i) begin
          off_d   = mod_rem_i;
          state_d = ST_PIECE;
        end
      end
      ST_PIECE: begin
        emit_req  = 1'b1;
        emit_kind = (mode_q == MODE_ONCE && CW'(wp_q) >= data_ext) ? KIND_SILENCE : KIND_DATA;
        emit_off  = off_q;
        emit_len  = piece_n_q;
        if (emit_ok) begin
          wp_d = wp_q + POS_BITS'(piece_n_q);
          if (two_q) begin
            two_d     = 1'b0;
            piece_n_d = tail_q;
            state_d   = ST_PIECE_MOD;
          end else if (after_q) begin
            state_d = ST_FILL_AFTER;
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_FILL_AFTER: begin
        if (mode_q == MODE_LOOP) begin
          emit_req  = 1'b1;
          emit_kind = KIND_REWIND;
          fill_go   = emit_ok;
        end else begin
          fill_go = 1'b1;
        end
        if (fill_go) begin
          sp_d    = sp_q + POS_BITS'(data_size_i);
          after_d = 1'b0;
          if (fill_n_q > first_q) begin
            if (CW'(rest_m) > data_ext) begin
              span_n_d = RB'(data_size_i);
            end else begin
              span_n_d = rest_m;
            end
            state_d = ST_SPAN_MOD;
          end else begin
            state_d = ST_END;
          end
        end
      end
      ST_END: begin
        if (out_free_i) begin
          push_o.valid = 1'b1;
          if (cnt_q == '0) begin
            push_o.beat.kind = KIND_NONE;
            push_o.beat.off  = '0;
            push_o.beat.len  = '0;
          end else begin
            push_o.beat = pend_q;
          end
          push_o.beat.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // one result held back so the final beat can be flagged
    if (emit_req && emit_ok && cnt_q != CNT_W'(RES_MAX)) begin
      if (pend_v_q) begin
        push_o.valid = 1'b1;
        push_o.beat  = pend_q;
      end
      pend_d.kind = emit_kind;
      pend_d.off  = OFF_W'(emit_off);
      pend_d.len  = LEN_W'(emit_len);
      pend_d.last = 1'b0;
      pend_v_d    = 1'b1;
      cnt_d       = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= MODE_STOP;
      wp_q     <= '0;
      sp_q     <= '0;
      play_q   <= '0;
      pivot_q  <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      wp_q     <= wp_d;
      sp_q     <= sp_d;
      play_q   <= play_d;
      pivot_q  <= pivot_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    cvalid_q  <= cvalid_d;
    cur_q     <= cur_d;
    tmp_q     <= tmp_d;
    room_q    <= room_d;
    fill_n_q  <= fill_n_d;
    first_q   <= first_d;
    span_n_q  <= span_n_d;
    piece_n_q <= piece_n_d;
    tail_q    <= tail_d;
    off_q     <= off_d;
    two_q     <= two_d;
    after_q   <= after_d;
  end

endmodule

FILE: rtl/audio_ring_refill_controller.sv
// ----------------------------------------------------------------------------
// audio_ring_refill_controller
// Refill controller for a circular playback buffer fed from a sound source.
// ----------------------------------------------------------------------------
//  channel   signals                                     direction
//  cfg       cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  write in
//  in        in_valid_i in_ready_o func_i cursor_valid_i
//            cursor_pos_i                                 item in
//  out       out_valid_o out_ready_i kind_o buf_offset_o
//            length_o last_o                              command out
//
//  One item at a time, in_ready_o high only in idle. A write piece passes
//  through a remainder unit start, a wait for the remainder and an emit.
//  A stalled out channel holds the sequencer at its next command beat; the
//  last beat of an item sits in the output register while a new item is taken.
//  Reset is asynchronous, active low, with no clearing pass.
// ----------------------------------------------------------------------------
module audio_ring_refill_controller import arrc_pkg::*; #(
  parameter int POS_BITS = POS_BITS_DEF,
  parameter int BUF_BITS = BUF_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic                 cursor_valid_i,
  input  logic [CUR_W-1:0]     cursor_pos_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           kind_o,
  output logic [OFF_W-1:0]     buf_offset_o,
  output logic [LEN_W-1:0]     length_o,
  output logic                 last_o
);

  localparam int RB = BUF_BITS + 1;
  localparam int RW = (BSIZE_W > RB) ? BSIZE_W : RB;
  localparam logic [RW-1:0] RING_LIM = RW'(1) << BUF_BITS;

  logic [BSIZE_W-1:0] buffer_size_q;
  logic [DSIZE_W-1:0] data_size_q;
  logic               loop_mode_q;
  logic [RW-1:0]      bsize_ext;
  logic [RB-1:0]      ring;
  logic               out_valid_q;
  beat_t              out_q;
  logic               out_free;
  out_push_t          push;
  logic               mod_start, mod_done;
  logic [POS_BITS-1:0] mod_dvd;
  logic [RB-1:0]      mod_rem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= BSIZE_RST;
      data_size_q   <= DSIZE_RST;
      loop_mode_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BUFFER_SIZE: buffer_size_q <= cfg_data_i[BSIZE_W-1:0];
        CFG_DATA_SIZE:   data_size_q   <= cfg_data_i[DSIZE_W-1:0];
        CFG_LOOP_MODE:   loop_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize saturates to the ring limit
  assign bsize_ext = RW'(buffer_size_q);
  always_comb begin
    if (bsize_ext == '0) begin
      ring = RB'(1);
    end else if (bsize_ext > RING_LIM) begin
      ring = RB'(RING_LIM);
    end else begin
      ring = RB'(bsize_ext);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  arrc_seq #(
    .POS_BITS(POS_BITS),
    .BUF_BITS(BUF_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .cursor_valid_i (cursor_valid_i),
    .cursor_pos_i   (cursor_pos_i),
    .ring_i         (ring),
    .data_size_i    (data_size_q),
    .loop_mode_i    (loop_mode_q),
    .out_free_i     (out_free),
    .push_o         (push),
    .mod_start_o    (mod_start),
    .mod_dvd_o      (mod_dvd),
    .mod_done_i     (mod_done),
    .mod_rem_i      (mod_rem)
  );

  arrc_mod_unit #(
    .POS_BITS(POS_BITS),
    .BUF_BITS(BUF_BITS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .dvd_i   (mod_dvd),
    .dvs_i   (ring),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // output register parts the sequencer from the command sink
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) out_q <= push.beat;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign buf_offset_o = out_q.off;
  assign length_o     = out_q.len;
  assign last_o       = out_q.last;

endmodule

FILE: rtl/arrc_checker.sv
// ----------------------------------------------------------------------------
// arrc_checker
// Port level checks of the refill controller, bound to the top level.
// ----------------------------------------------------------------------------
module arrc_checker import arrc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       kind_o,
  input logic [OFF_W-1:0] buf_offset_o,
  input logic [LEN_W-1:0] length_o,
  input logic             last_o
);

  // a stalled command beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) &&
    $stable(buf_offset_o) && $stable(length_o) && $stable(last_o))
    else $error("command beat changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_DATA || kind_o == KIND_SILENCE ||
    kind_o == KIND_REWIND || kind_o == KIND_STOP || kind_o == KIND_NONE))
    else $error("illegal command kind");

  a_ctrl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_REWIND || kind_o == KIND_STOP ||
    kind_o == KIND_NONE) |-> buf_offset_o == '0 && length_o == '0)
    else $error("control command carries offset or length");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_NONE |-> last_o)
    else $error("no action beat not flagged last");

endmodule

bind audio_ring_refill_controller arrc_checker u_arrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .buf_offset_o (buf_offset_o),
  .length_o     (length_o),
  .last_o       (last_o)
);
